[rtl/core/twoa_pkg.sv]
// Shared constants, codes and types for the time-weighted occupancy average block.
// Used by twoa_divider and time_weighted_occupancy_average_top; no dependencies.
package twoa_pkg;

   localparam int COUNT_W   = 16;
   localparam int TIME_W    = 48;
   localparam int FRAC_BITS = 16;
   localparam int TS_W      = 48;
   localparam int AREA_W    = 64;
   localparam int QUOT_W    = 32;
   localparam int INT_BITS  = QUOT_W - FRAC_BITS;
   localparam int PROD_W    = COUNT_W + TIME_W;
   localparam int STEP_W    = $clog2(QUOT_W);
   localparam int WIDE_W    = AREA_W + QUOT_W;

   typedef enum logic [1:0] {
      REQ_RESTART   = 2'd0,
      REQ_ARRIVAL   = 2'd1,
      REQ_DEPARTURE = 2'd2,
      REQ_REPORT    = 2'd3
   } req_code_type;

   typedef struct packed {
      logic done;
      logic zero_window;
   } div_status_type;

   // elapsed time, zero when time runs backwards
   function automatic logic [TIME_W-1:0] span(input logic [TIME_W-1:0] from_t,
                                              input logic [TIME_W-1:0] to_t);
      span = (to_t >= from_t) ? (to_t - from_t) : '0;
   endfunction

endpackage

[rtl/core/twoa_divider.sv]
// Fixed-point divider: area / window with FRAC_BITS fraction bits, saturating.
// Restoring division, one quotient bit per cycle. Depends on twoa_pkg.
module twoa_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [twoa_pkg::AREA_W-1:0]       area_sum,
   input  logic [twoa_pkg::TIME_W-1:0]       window,
   output twoa_pkg::div_status_type          status,
   output logic [twoa_pkg::QUOT_W-1:0]       quotient
);

   typedef enum logic [3:0] {
      D_IDLE  = 4'b0001,
      D_CHECK = 4'b0010,
      D_RUN   = 4'b0100,
      D_DONE  = 4'b1000
   } div_state_type;

   div_state_type                     state_ff, state_in;
   logic [twoa_pkg::AREA_W-1:0]       area_ff, area_in;
   logic [twoa_pkg::TIME_W-1:0]       win_ff, win_in;
   logic [twoa_pkg::TIME_W-1:0]       rem_ff, rem_in;
   logic [twoa_pkg::QUOT_W-1:0]       quot_ff, quot_in;
   logic [twoa_pkg::STEP_W-1:0]       step_ff, step_in;
   logic                              zero_ff, zero_in;

   logic [twoa_pkg::WIDE_W-1:0]       limit;
   logic                              too_big;
   logic [twoa_pkg::TIME_W:0]         rem_sh;
   logic [twoa_pkg::TIME_W:0]         rem_diff;
   logic                              fits;

   assign limit    = twoa_pkg::WIDE_W'(win_ff) << twoa_pkg::INT_BITS;
   assign too_big  = twoa_pkg::WIDE_W'(area_ff) >= limit;
   assign rem_sh   = {rem_ff, quot_ff[twoa_pkg::QUOT_W-1]};
   assign rem_diff = rem_sh - {1'b0, win_ff};
   assign fits     = rem_sh >= {1'b0, win_ff};

   always_comb begin
      state_in = state_ff;
      area_in  = area_ff;
      win_in   = win_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      step_in  = step_ff;
      zero_in  = zero_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               area_in  = area_sum;
               win_in   = window;
               state_in = D_CHECK;
            end
         end
         D_CHECK: begin
            zero_in = 1'b0;
            step_in = '0;
            if (win_ff == '0) begin
               quot_in  = '0;
               zero_in  = 1'b1;
               state_in = D_DONE;
            end else if (too_big) begin
               quot_in  = '1;
               state_in = D_DONE;
            end else begin
               // quotient < 2^QUOT_W, so the upper dividend bits start as remainder
               rem_in   = twoa_pkg::TIME_W'(area_ff >> twoa_pkg::INT_BITS);
               quot_in  = twoa_pkg::QUOT_W'(area_ff) << twoa_pkg::FRAC_BITS;
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            rem_in  = fits ? rem_diff[twoa_pkg::TIME_W-1:0] : rem_sh[twoa_pkg::TIME_W-1:0];
            quot_in = {quot_ff[twoa_pkg::QUOT_W-2:0], fits};
            step_in = step_ff + 1'b1;
            if (step_ff == twoa_pkg::STEP_W'(twoa_pkg::QUOT_W - 1)) begin
               state_in = D_DONE;
            end
         end
         D_DONE: begin
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         zero_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         zero_ff  <= zero_in;
      end
      area_ff <= area_in;
      win_ff  <= win_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
   end

   assign status.done        = (state_ff == D_DONE);
   assign status.zero_window = zero_ff;
   assign quotient           = quot_ff;

endmodule

[rtl/core/time_weighted_occupancy_average_top.sv]
// Time-weighted occupancy average: restart, arrival, departure and report items.
// Restart is done on acceptance; arrival and departure pass through multiply and accumulate.
// Report also multiplies and accumulates, then runs the bit-serial divider (one bit per cycle).
// One item at a time; a finished result waits in the output register.
// Synchronous active-high reset clears occupancy, times, area and the output valid.
// Depends on twoa_pkg and twoa_divider.
module time_weighted_occupancy_average_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_type,
   input  logic [twoa_pkg::TS_W-1:0]     req_timestamp_us,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [twoa_pkg::QUOT_W-1:0]   rsp_average_q16,
   output logic                          rsp_zero_window
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_ACC  = 5'b00100,
      S_DIV  = 5'b01000,
      S_FIN  = 5'b10000
   } top_state_type;

   top_state_type                         state_ff, state_in;
   twoa_pkg::req_code_type                code_ff, code_in;
   logic [twoa_pkg::TIME_W-1:0]           now_ff, now_in;
   logic [twoa_pkg::COUNT_W-1:0]          occ_ff, occ_in;
   logic [twoa_pkg::TIME_W-1:0]           last_ff, last_in;
   logic [twoa_pkg::TIME_W-1:0]           start_ff, start_in;
   logic [twoa_pkg::AREA_W-1:0]           area_ff, area_in;
   logic [twoa_pkg::PROD_W-1:0]           prod_ff, prod_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [twoa_pkg::QUOT_W-1:0]           avg_ff, avg_in;
   logic                                  zero_ff, zero_in;

   logic [twoa_pkg::AREA_W+twoa_pkg::PROD_W-1:0] prod_wide;
   logic [twoa_pkg::AREA_W-1:0]           prod_clip;
   logic [twoa_pkg::AREA_W:0]             sum;
   logic [twoa_pkg::AREA_W-1:0]           area_acc;
   logic                                  div_start;
   twoa_pkg::div_status_type              div_status;
   logic [twoa_pkg::QUOT_W-1:0]           div_quot;
   logic                                  req_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign prod_wide = (twoa_pkg::AREA_W + twoa_pkg::PROD_W)'(prod_ff);
   assign prod_clip = ((prod_wide >> twoa_pkg::AREA_W) == '0)
                    ? twoa_pkg::AREA_W'(prod_ff) : '1;
   assign sum       = {1'b0, area_ff} + {1'b0, prod_clip};
   assign area_acc  = sum[twoa_pkg::AREA_W] ? '1 : sum[twoa_pkg::AREA_W-1:0];
   assign div_start = (state_ff == S_ACC) && (code_ff == twoa_pkg::REQ_REPORT);

   twoa_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .area_sum (area_acc),
      .window   (twoa_pkg::span(start_ff, now_ff)),
      .status   (div_status),
      .quotient (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      now_in       = now_ff;
      occ_in       = occ_ff;
      last_in      = last_ff;
      start_in     = start_ff;
      area_in      = area_ff;
      prod_in      = prod_ff;
      avg_in       = avg_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               code_in = twoa_pkg::req_code_type'(req_type);
               now_in  = twoa_pkg::TIME_W'(req_timestamp_us);
               if (twoa_pkg::req_code_type'(req_type) == twoa_pkg::REQ_RESTART) begin
                  occ_in   = '0;
                  area_in  = '0;
                  last_in  = twoa_pkg::TIME_W'(req_timestamp_us);
                  start_in = twoa_pkg::TIME_W'(req_timestamp_us);
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            prod_in  = twoa_pkg::PROD_W'(occ_ff)
                     * twoa_pkg::PROD_W'(twoa_pkg::span(last_ff, now_ff));
            state_in = S_ACC;
         end
         S_ACC: begin
            area_in  = area_acc;
            last_in  = now_ff;
            state_in = S_IDLE;
            case (code_ff)
               twoa_pkg::REQ_ARRIVAL: begin
                  if (occ_ff != '1) begin
                     occ_in = occ_ff + 1'b1;
                  end
               end
               twoa_pkg::REQ_DEPARTURE: begin
                  if (occ_ff != '0) begin
                     occ_in = occ_ff - 1'b1;
                  end
               end
               twoa_pkg::REQ_REPORT: begin
                  state_in = S_DIV;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_DIV: begin
            if (div_status.done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               avg_in       = div_quot;
               zero_in      = div_status.zero_window;
               rsp_valid_in = 1'b1;
               area_in      = '0;
               start_in     = now_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         occ_ff       <= '0;
         last_ff      <= '0;
         start_ff     <= '0;
         area_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         occ_ff       <= occ_in;
         last_ff      <= last_in;
         start_ff     <= start_in;
         area_ff      <= area_in;
      end
      code_ff <= code_in;
      now_ff  <= now_in;
      prod_ff <= prod_in;
      avg_ff  <= avg_in;
      zero_ff <= zero_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_average_q16 = avg_ff;
   assign rsp_zero_window = zero_ff;

endmodule
